// File: hw/rtl/tipe_pkg.sv
package tipe_pkg;

    // store geometry and record limits
    localparam int AW          = 20;
    localparam int TAPE_BYTES  = 1 << AW;
    localparam int HW          = AW + 1;
    localparam int MAX_RECORD  = 65534;

    localparam logic [31:0] END_MARK = 32'hffff_ffff;
    localparam logic [31:0] BAD_LEN  = 32'hff00_0000;
    localparam logic [33:0] TAPE_W   = 34'(TAPE_BYTES);

    typedef enum logic [2:0] {
        OP_TEST     = 3'd0,
        OP_REWIND   = 3'd1,
        OP_READ     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_FILEMARK = 3'd4,
        OP_SPACE    = 3'd5,
        OP_PEEK     = 3'd6,
        OP_POKE     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CHECK     = 2'd1,
        ST_ERROR     = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    localparam logic [1:0] MODE_BLOCKS = 2'd0;
    localparam logic [1:0] MODE_FILES  = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_WWORD,
        S_RD1,
        S_RD2,
        S_WR1,
        S_WR2,
        S_FM1,
        S_SP_LOOP,
        S_F1,
        S_F2,
        S_B1,
        S_B2,
        S_SP_END,
        S_PEEK,
        S_FINISH
    } state_t;

endpackage

// File: hw/rtl/tipe_mem.sv
module tipe_mem (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [tipe_pkg::AW-1:0] wr_addr,
    input  logic [7:0]              wr_data,
    input  logic [tipe_pkg::AW-1:0] rd_addr,
    output logic [7:0]              rd_data
);
    import tipe_pkg::*;

    logic [7:0] mem [TAPE_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/tape_image_positioning_engine.sv
// channel   | handshake        | words
// s_ (cmd)  | s_valid/s_ready  | op, count, space_mode, dma_armed, byte_address, byte_in
// m_ (resp) | m_valid/m_ready  | status, flags, residual, offsets, counters
// cfg       | cfg_write_en     | tape_mounted, written at once
// one command at a time: a length word is read or written over the single byte port;
// space reads the length words at both ends of each record walked
// reset clears head, counters and the mount flag; the store itself is not cleared
// the response waits in its own register so a new command is taken while it stalls
module tape_image_positioning_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_write_en,
    input  logic                        cfg_write_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_op,
    input  logic [23:0]                 s_count,
    input  logic [1:0]                  s_space_mode,
    input  logic                        s_dma_armed,
    input  logic [tipe_pkg::AW-1:0]     s_byte_address,
    input  logic [7:0]                  s_byte_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic                        m_filemark,
    output logic                        m_end_of_medium,
    output logic                        m_length_mismatch,
    output logic                        m_begin_of_tape,
    output logic                        m_format_error,
    output logic signed [24:0]          m_residual,
    output logic [tipe_pkg::HW-1:0]     m_data_offset,
    output logic [15:0]                 m_record_length,
    output logic [7:0]                  m_byte_out,
    output logic [15:0]                 m_file_number,
    output logic [15:0]                 m_record_number
);
    import tipe_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic          mounted_reg;
    logic [2:0]    op_reg, op_next;
    logic [23:0]   cnt_reg, cnt_next;
    logic [1:0]    mode_reg, mode_next;
    logic          armed_reg, armed_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    bin_reg, bin_next;

    logic [HW-1:0] head_reg, head_next;
    logic [15:0]   file_reg, file_next;
    logic [15:0]   rec_reg, rec_next;
    logic [23:0]   x_reg, x_next;
    logic          neg_reg, neg_next;
    logic [31:0]   word_reg, word_next;
    logic [31:0]   len_reg, len_next;
    logic [HW-1:0] span_reg, span_next;
    logic [2:0]    k_reg, k_next;
    logic [AW-1:0] faddr_reg, faddr_next;
    logic [AW-1:0] waddr_reg, waddr_next;
    logic [31:0]   wdata_reg, wdata_next;

    logic [1:0]    st_reg, st_next;
    logic          fm_reg, fm_next, eom_reg, eom_next, lm_reg, lm_next;
    logic          bot_reg, bot_next, fe_reg, fe_next;
    logic [24:0]   res_reg, res_next;
    logic [HW-1:0] doff_reg, doff_next;
    logic [15:0]   rlen_reg, rlen_next;
    logic [7:0]    bout_reg, bout_next;

    logic          m_valid_reg;

    // byte port
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd, mem_rd;

    tipe_mem u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    // shared address and length arithmetic
    logic [33:0] head_w;
    logic [32:0] w_pad;
    logic [33:0] w_span;
    logic [25:0] c_body;
    logic        fit4, fit8, head_ge4, fwd_fit, bwd_fit, wr_fit;
    logic        w_zero, w_end, w_bad, w_match, rd_fail, x_zero, cnt_big;

    always_comb begin
        head_w   = {13'd0, head_reg};
        w_pad    = {1'b0, word_reg} + {32'd0, word_reg[0]};
        w_span   = {1'b0, w_pad} + 34'd8;
        c_body   = {2'b0, cnt_reg} + {25'd0, cnt_reg[0]};
        fit4     = (head_w + 34'd4) <= TAPE_W;
        fit8     = (head_w + 34'd8) <= TAPE_W;
        head_ge4 = head_reg >= HW'(4);
        fwd_fit  = (head_w + w_span) <= TAPE_W;
        bwd_fit  = head_w >= w_span;
        wr_fit   = (head_w + {8'd0, c_body} + 34'd12) <= TAPE_W;
        w_zero   = word_reg == 32'd0;
        w_end    = word_reg == END_MARK;
        w_bad    = word_reg >= BAD_LEN;
        w_match  = word_reg == len_reg;
        cnt_big  = {8'd0, cnt_reg} > 32'(MAX_RECORD);
        rd_fail  = (word_reg > 32'(MAX_RECORD)) || (word_reg > {8'd0, cnt_reg}) || !fwd_fit;
        x_zero   = x_reg == 24'd0;
    end

    assign s_ready = state_reg == S_IDLE;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (op_reg)
                    OP_READ:     state_next = (armed_reg && fit4) ? S_FETCH : S_FINISH;
                    OP_WRITE:    state_next = (armed_reg && !cnt_big && wr_fit) ? S_WWORD
                                                                                 : S_FINISH;
                    OP_FILEMARK: state_next = fit8 ? S_WWORD : S_FINISH;
                    OP_SPACE:    state_next = S_SP_LOOP;
                    OP_PEEK:     state_next = S_PEEK;
                    default:     state_next = S_FINISH;
                endcase
            end
            S_FETCH: begin
                if (k_reg == 3'd4) state_next = ret_reg;
            end
            S_WWORD: begin
                if (k_reg == 3'd3) state_next = ret_reg;
            end
            S_RD1: begin
                state_next = (w_zero || w_end || rd_fail) ? S_FINISH : S_FETCH;
            end
            S_RD2:   state_next = S_FINISH;
            S_WR1:   state_next = S_WWORD;
            S_WR2:   state_next = S_WWORD;
            S_FM1:   state_next = S_WWORD;
            S_SP_LOOP: begin
                if (x_zero || mode_reg[1]) begin
                    state_next = S_SP_END;
                end else if (x_reg[23]) begin
                    state_next = head_ge4 ? S_FETCH : S_SP_END;
                end else begin
                    state_next = fit4 ? S_FETCH : S_SP_END;
                end
            end
            S_F1: begin
                if (w_zero) begin
                    state_next = (mode_reg == MODE_FILES) ? S_SP_LOOP : S_SP_END;
                end else if (w_bad || !fwd_fit) begin
                    state_next = S_SP_END;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_B1: begin
                if (w_zero) begin
                    state_next = (mode_reg == MODE_FILES) ? S_SP_LOOP : S_SP_END;
                end else if (w_bad || !bwd_fit) begin
                    state_next = S_SP_END;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_F2, S_B2: state_next = w_match ? S_SP_LOOP : S_SP_END;
            S_SP_END:   state_next = S_FINISH;
            S_PEEK:     state_next = S_FINISH;
            S_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        ret_next   = ret_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        armed_next = armed_reg;
        addr_next  = addr_reg;
        bin_next   = bin_reg;
        head_next  = head_reg;
        file_next  = file_reg;
        rec_next   = rec_reg;
        x_next     = x_reg;
        neg_next   = neg_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        span_next  = span_reg;
        k_next     = 3'd0;
        faddr_next = faddr_reg;
        waddr_next = waddr_reg;
        wdata_next = wdata_reg;
        st_next    = st_reg;
        fm_next    = fm_reg;
        eom_next   = eom_reg;
        lm_next    = lm_reg;
        bot_next   = bot_reg;
        fe_next    = fe_reg;
        res_next   = res_reg;
        doff_next  = doff_reg;
        rlen_next  = rlen_reg;
        bout_next  = bout_reg;
        mem_we     = 1'b0;
        mem_wa     = waddr_reg + AW'(k_reg[1:0]);
        mem_wd     = wdata_reg[8*k_reg[1:0] +: 8];
        mem_ra     = faddr_reg + AW'(k_reg[1:0]);

        unique case (state_reg)
            S_IDLE: begin
                op_next    = s_op;
                cnt_next   = s_count;
                mode_next  = s_space_mode;
                armed_next = s_dma_armed;
                addr_next  = s_byte_address;
                bin_next   = s_byte_in;
            end
            S_DISPATCH: begin
                st_next   = ST_OK;
                fm_next   = 1'b0;
                eom_next  = 1'b0;
                lm_next   = 1'b0;
                bot_next  = 1'b0;
                fe_next   = 1'b0;
                res_next  = 25'd0;
                doff_next = '0;
                rlen_next = 16'd0;
                bout_next = 8'd0;
                mem_ra    = addr_reg;
                unique case (op_reg)
                    OP_TEST: begin
                        if (!mounted_reg) st_next = ST_NOT_READY;
                    end
                    OP_REWIND: begin
                        head_next = '0;
                        file_next = 16'd0;
                        rec_next  = 16'd0;
                    end
                    OP_READ: begin
                        if (armed_reg) begin
                            if (!fit4) begin
                                st_next  = ST_ERROR;
                                fe_next  = 1'b1;
                                res_next = {1'b0, cnt_reg};
                            end else begin
                                faddr_next = head_reg[AW-1:0];
                                ret_next   = S_RD1;
                            end
                        end
                    end
                    OP_WRITE: begin
                        if (armed_reg) begin
                            if (cnt_big || !wr_fit) begin
                                st_next = ST_ERROR;
                                fe_next = 1'b1;
                            end else begin
                                waddr_next = head_reg[AW-1:0];
                                wdata_next = {8'd0, cnt_reg};
                                doff_next  = head_reg + HW'(4);
                                rlen_next  = cnt_reg[15:0];
                                ret_next   = S_WR1;
                            end
                        end
                    end
                    OP_FILEMARK: begin
                        if (!fit8) begin
                            st_next = ST_ERROR;
                            fe_next = 1'b1;
                        end else begin
                            waddr_next = head_reg[AW-1:0];
                            wdata_next = 32'd0;
                            ret_next   = S_FM1;
                        end
                    end
                    OP_SPACE: begin
                        x_next   = cnt_reg;
                        neg_next = cnt_reg[23];
                    end
                    OP_POKE: begin
                        mem_we = 1'b1;
                        mem_wa = addr_reg;
                        mem_wd = bin_reg;
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                k_next = k_reg + 3'd1;
                if (k_reg != 3'd0) begin
                    word_next[8*(k_reg - 3'd1) +: 8] = mem_rd;
                end
            end
            S_WWORD: begin
                mem_we = 1'b1;
                k_next = k_reg + 3'd1;
            end
            S_RD1: begin
                len_next  = word_reg;
                span_next = w_span[HW-1:0];
                if (w_zero) begin
                    st_next   = ST_CHECK;
                    fm_next   = 1'b1;
                    res_next  = {1'b0, cnt_reg};
                    head_next = head_reg + HW'(4);
                    rec_next  = 16'd0;
                    file_next = file_reg + 16'd1;
                end else if (w_end) begin
                    st_next  = ST_ERROR;
                    eom_next = 1'b1;
                    res_next = {1'b0, cnt_reg};
                end else if (rd_fail) begin
                    st_next  = ST_ERROR;
                    fe_next  = 1'b1;
                    res_next = {1'b0, cnt_reg};
                end else begin
                    faddr_next = head_reg[AW-1:0] + AW'(4) + w_pad[AW-1:0];
                    ret_next   = S_RD2;
                end
            end
            S_RD2: begin
                if (!w_match) begin
                    st_next  = ST_ERROR;
                    fe_next  = 1'b1;
                    res_next = {1'b0, cnt_reg};
                end else begin
                    doff_next = head_reg + HW'(4);
                    rlen_next = len_reg[15:0];
                    head_next = head_reg + span_reg;
                    rec_next  = rec_reg + 16'd1;
                    if (len_reg[23:0] != cnt_reg) begin
                        st_next  = ST_CHECK;
                        lm_next  = 1'b1;
                        res_next = {1'b0, cnt_reg - len_reg[23:0]};
                    end
                end
            end
            S_WR1: begin
                waddr_next = head_reg[AW-1:0] + AW'(4) + c_body[AW-1:0];
                head_next  = head_reg + HW'(8) + c_body[HW-1:0];
                rec_next   = rec_reg + 16'd1;
                ret_next   = S_WR2;
            end
            S_WR2: begin
                waddr_next = head_reg[AW-1:0];
                wdata_next = END_MARK;
                ret_next   = S_FINISH;
            end
            S_FM1: begin
                waddr_next = head_reg[AW-1:0] + AW'(4);
                wdata_next = END_MARK;
                head_next  = head_reg + HW'(4);
                rec_next   = 16'd0;
                file_next  = file_reg + 16'd1;
                ret_next   = S_FINISH;
            end
            S_SP_LOOP: begin
                if (!x_zero && !mode_reg[1]) begin
                    if (x_reg[23]) begin
                        faddr_next = head_reg[AW-1:0] - AW'(4);
                        ret_next   = S_B1;
                    end else if (!fit4) begin
                        fe_next = 1'b1;
                    end else begin
                        faddr_next = head_reg[AW-1:0];
                        ret_next   = S_F1;
                    end
                end
            end
            S_F1: begin
                len_next  = word_reg;
                span_next = w_span[HW-1:0];
                if (w_zero) begin
                    if (mode_reg == MODE_FILES) begin
                        head_next = head_reg + HW'(4);
                        file_next = file_reg + 16'd1;
                        rec_next  = 16'd0;
                        x_next    = x_reg - 24'd1;
                    end else begin
                        fe_next = 1'b1;
                    end
                end else if (w_bad || !fwd_fit) begin
                    fe_next = 1'b1;
                end else begin
                    faddr_next = head_reg[AW-1:0] + AW'(4) + w_pad[AW-1:0];
                    ret_next   = S_F2;
                end
            end
            S_F2: begin
                if (w_match) begin
                    head_next = head_reg + span_reg;
                    rec_next  = rec_reg + 16'd1;
                    if (mode_reg == MODE_BLOCKS) x_next = x_reg - 24'd1;
                end else begin
                    fe_next = 1'b1;
                end
            end
            S_B1: begin
                len_next  = word_reg;
                span_next = w_span[HW-1:0];
                if (w_zero) begin
                    if (mode_reg == MODE_FILES) begin
                        head_next = head_reg - HW'(4);
                        file_next = file_reg - 16'd1;
                        x_next    = x_reg + 24'd1;
                    end
                end else if (w_bad || !bwd_fit) begin
                    fe_next = 1'b1;
                end else begin
                    faddr_next = head_reg[AW-1:0] - w_span[AW-1:0];
                    ret_next   = S_B2;
                end
            end
            S_B2: begin
                if (w_match) begin
                    head_next = head_reg - span_reg;
                    rec_next  = rec_reg - 16'd1;
                    if (mode_reg == MODE_BLOCKS) x_next = x_reg + 24'd1;
                end else begin
                    fe_next = 1'b1;
                end
            end
            S_SP_END: begin
                res_next = {x_reg[23], x_reg};
                if (!x_zero || fe_reg) st_next = ST_ERROR;
                if (mode_reg == MODE_FILES && neg_reg) begin
                    rec_next = 16'd0;
                    if (!x_zero && !fe_reg) begin
                        eom_next  = 1'b1;
                        bot_next  = 1'b1;
                        file_next = 16'd0;
                        head_next = '0;
                    end
                end
            end
            S_PEEK: begin
                bout_next = mem_rd;
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            mounted_reg <= 1'b0;
            head_reg    <= '0;
            file_reg    <= 16'd0;
            rec_reg     <= 16'd0;
            k_reg       <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            head_reg  <= head_next;
            file_reg  <= file_next;
            rec_reg   <= rec_next;
            k_reg     <= k_next;
            if (cfg_write_en) mounted_reg <= cfg_write_data;
            if (state_reg == S_FINISH && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        cnt_reg   <= cnt_next;
        mode_reg  <= mode_next;
        armed_reg <= armed_next;
        addr_reg  <= addr_next;
        bin_reg   <= bin_next;
        x_reg     <= x_next;
        neg_reg   <= neg_next;
        word_reg  <= word_next;
        len_reg   <= len_next;
        span_reg  <= span_next;
        faddr_reg <= faddr_next;
        waddr_reg <= waddr_next;
        wdata_reg <= wdata_next;
        st_reg    <= st_next;
        fm_reg    <= fm_next;
        eom_reg   <= eom_next;
        lm_reg    <= lm_next;
        bot_reg   <= bot_next;
        fe_reg    <= fe_next;
        res_reg   <= res_next;
        doff_reg  <= doff_next;
        rlen_reg  <= rlen_next;
        bout_reg  <= bout_next;
        if (state_reg == S_FINISH && (!m_valid_reg || m_ready)) begin
            m_status          <= st_reg;
            m_filemark        <= fm_reg;
            m_end_of_medium   <= eom_reg;
            m_length_mismatch <= lm_reg;
            m_begin_of_tape   <= bot_reg;
            m_format_error    <= fe_reg;
            m_residual        <= res_reg;
            m_data_offset     <= doff_reg;
            m_record_length   <= rlen_reg;
            m_byte_out        <= bout_reg;
            m_file_number     <= file_reg;
            m_record_number   <= rec_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
